// File: design/sorted_timer_event_queue_defines.svh
// Assertion macros shared by the timer event queue.
`ifndef SORTED_TIMER_EVENT_QUEUE_DEFINES_SVH
`define SORTED_TIMER_EVENT_QUEUE_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define STEQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked on every clock edge outside reset.
`define STEQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/steq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer event queue package
// Widths, entry record, opcodes, status codes and sequencer states.
// ----------------------------------------------------------------------------
package steq_pkg;

  localparam int QueueDepth = 16;
  localparam int TimeBits   = 32;
  localparam int OwnerBits  = 8;
  localparam int IdxBits    = $clog2(QueueDepth);
  localparam int CntBits    = $clog2(QueueDepth + 1);
  localparam int EntryBits  = TimeBits + 4 + 1 + OwnerBits + 1;

  typedef struct packed {
    logic [TimeBits-1:0]  expiry;
    logic [3:0]           etype;
    logic                 owned;
    logic [OwnerBits-1:0] owner;
    logic                 kind;
  } entry_t;

  typedef enum logic [2:0] {
    OP_SCHED  = 3'd0,
    OP_POPEXP = 3'd1,
    OP_POP    = 3'd2,
    OP_CANCEL = 3'd3,
    OP_QUERY  = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_NOTDUE   = 3'd2,
    ST_FULL     = 3'd3,
    ST_BUSY     = 3'd4,
    ST_NOTFOUND = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT_UP,
    S_SHIFT_DN,
    S_DONE
  } state_t;

endpackage

// File: design/steq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module steq_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/sorted_timer_event_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted timer event queue
// Up to QueueDepth timer events held in expiry order in one RAM.
// ----------------------------------------------------------------------------
// Usage: pulse start with an item on the in_ ports while busy is low. The
// block answers every item with exactly one result, marked by out_valid for
// a single cycle; the receiver cannot stall and need not.
// Entries sit in one RAM in ascending expiry order. The sequencer scans the
// queue one entry per cycle (the RAM read port sets the pace) to find the
// insert point or the owner's entry, then shifts entries, each by a read and
// a write, to open or close a gap. A query, an unused opcode or any item but
// a schedule that finds the queue empty is answered from the first scan step.
// Busy stays high until the result is registered. A schedule scans every
// entry and shifts those at and behind the insert point; a pop shifts the
// entries behind the head; a cancel shifts those behind the owner's entry.
// The worst case is a schedule to the head of 15 entries.
// cfg_we writes the retransmit type code at any edge; use it only while idle.
// Reset empties the queue and clears the register; the RAM is not cleared,
// since entries at or above the count are never used.
// ----------------------------------------------------------------------------
module sorted_timer_event_queue (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_opcode,
  input  logic [31:0] in_now_time,
  input  logic [31:0] in_delay,
  input  logic [3:0]  in_evt_code,
  input  logic        in_has_owner,
  input  logic [7:0]  in_owner_id,
  input  logic        in_slot_kind,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [3:0]  out_evt_code,
  output logic        out_has_owner,
  output logic [7:0]  out_owner_id,
  output logic        out_slot_kind,
  output logic [31:0] out_wait_time,
  output logic        out_retransmit_cleared
);

  localparam int TB = steq_pkg::TimeBits;
  localparam int IB = steq_pkg::IdxBits;
  localparam int CB = steq_pkg::CntBits;

  steq_pkg::state_t state_r, state_nxt;
  logic [CB-1:0] count_r, count_nxt;
  logic [CB-1:0] idx_r, idx_nxt;
  logic [CB-1:0] pos_r, pos_nxt;
  logic          found_r, found_nxt;
  logic [3:0]    rtc_r;

  logic [2:0]          op_r;
  logic [TB-1:0]       now_r, exp_r;
  steq_pkg::entry_t    new_r;

  logic [2:0]  res_status_r, res_status_nxt;
  logic [3:0]  res_type_r, res_type_nxt;
  logic        res_owned_r, res_owned_nxt;
  logic [7:0]  res_owner_r, res_owner_nxt;
  logic        res_kind_r, res_kind_nxt;
  logic [31:0] res_wait_r, res_wait_nxt;
  logic        res_rtc_r, res_rtc_nxt;
  logic        valid_r, valid_nxt;

  logic                        we;
  logic [IB-1:0]               waddr, raddr;
  steq_pkg::entry_t            wdata, rdata;
  logic [steq_pkg::EntryBits-1:0] rdata_bits;
  logic                        rd_pend_r, rd_pend_nxt;

  logic [TB:0] sum;
  logic        accept;

  steq_ram #(.Width(steq_pkg::EntryBits), .Depth(steq_pkg::QueueDepth)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata_bits)
  );
  assign rdata = steq_pkg::entry_t'(rdata_bits);

  assign accept = start && !busy;
  assign busy   = (state_r != steq_pkg::S_IDLE);
  assign sum    = {1'b0, in_now_time[TB-1:0]} + {1'b0, in_delay[TB-1:0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rtc_r <= '0;
    end else if (cfg_we) begin
      rtc_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r           <= in_opcode;
      now_r          <= in_now_time[TB-1:0];
      exp_r          <= sum[TB] ? '1 : sum[TB-1:0];
      new_r.expiry   <= sum[TB] ? '1 : sum[TB-1:0];
      new_r.etype    <= in_evt_code;
      new_r.owned    <= in_has_owner;
      new_r.owner    <= in_has_owner ? in_owner_id[steq_pkg::OwnerBits-1:0] : '0;
      new_r.kind     <= in_has_owner ? in_slot_kind : 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= steq_pkg::S_IDLE;
      count_r   <= '0;
      valid_r   <= 1'b0;
      rd_pend_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      valid_r   <= valid_nxt;
      rd_pend_r <= rd_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    pos_r        <= pos_nxt;
    found_r      <= found_nxt;
    res_status_r <= res_status_nxt;
    res_type_r   <= res_type_nxt;
    res_owned_r  <= res_owned_nxt;
    res_owner_r  <= res_owner_nxt;
    res_kind_r   <= res_kind_nxt;
    res_wait_r   <= res_wait_nxt;
    res_rtc_r    <= res_rtc_nxt;
  end

  // Scan: address idx is issued, data arrives in the next cycle while rd_pend_r.
  // A read-ahead of one entry runs so a scan step need not wait for its data.
  always_comb begin
    logic [CB-1:0] cur;
    logic          hit;
    state_nxt      = state_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    pos_nxt        = pos_r;
    found_nxt      = found_r;
    res_status_nxt = res_status_r;
    res_type_nxt   = res_type_r;
    res_owned_nxt  = res_owned_r;
    res_owner_nxt  = res_owner_r;
    res_kind_nxt   = res_kind_r;
    res_wait_nxt   = res_wait_r;
    res_rtc_nxt    = res_rtc_r;
    valid_nxt      = 1'b0;
    rd_pend_nxt    = 1'b0;
    we             = 1'b0;
    waddr          = idx_r[IB-1:0];
    wdata          = rdata;
    raddr          = idx_r[IB-1:0];
    cur            = idx_r - CB'(1);
    hit            = 1'b0;
    case (state_r)
      steq_pkg::S_IDLE: begin
        if (accept) begin
          res_status_nxt = steq_pkg::ST_OK;
          res_type_nxt   = '0;
          res_owned_nxt  = 1'b0;
          res_owner_nxt  = '0;
          res_kind_nxt   = 1'b0;
          res_wait_nxt   = '0;
          res_rtc_nxt    = 1'b0;
          found_nxt      = 1'b0;
          idx_nxt        = CB'(1);
          pos_nxt        = '0;
          raddr          = '0;
          rd_pend_nxt    = 1'b1;
          state_nxt      = steq_pkg::S_SCAN;
        end
      end
      steq_pkg::S_SCAN: begin
        // idx_r - 1 is the entry whose data is on rdata.
        raddr       = idx_r[IB-1:0];
        rd_pend_nxt = 1'b1;
        idx_nxt     = idx_r + CB'(1);
        state_nxt   = steq_pkg::S_DONE;
        case (op_r)
          steq_pkg::OP_SCHED: begin
            if (cur < count_r) begin
              hit = rdata.owned && new_r.owned && rdata.owner == new_r.owner &&
                    rdata.kind == new_r.kind;
              if (hit) begin
                found_nxt = 1'b1;
              end
              if (!found_r && rdata.expiry < exp_r) begin
                pos_nxt = idx_r;
              end
              state_nxt = steq_pkg::S_SCAN;
            end else if (found_r) begin
              res_status_nxt = steq_pkg::ST_BUSY;
            end else if (count_r >= CB'(steq_pkg::QueueDepth)) begin
              res_status_nxt = steq_pkg::ST_FULL;
            end else begin
              idx_nxt     = count_r;
              rd_pend_nxt = 1'b0;
              state_nxt   = steq_pkg::S_SHIFT_UP;
            end
          end
          steq_pkg::OP_POPEXP, steq_pkg::OP_POP: begin
            if (count_r == '0) begin
              res_status_nxt = steq_pkg::ST_EMPTY;
            end else if (op_r == steq_pkg::OP_POPEXP && now_r < rdata.expiry) begin
              res_status_nxt = steq_pkg::ST_NOTDUE;
            end else begin
              res_type_nxt  = rdata.etype;
              res_owned_nxt = rdata.owned;
              res_owner_nxt = 8'(rdata.owner);
              res_kind_nxt  = rdata.kind;
              pos_nxt       = '0;
              idx_nxt       = CB'(1);
              raddr         = IB'(1);
              state_nxt     = steq_pkg::S_SHIFT_DN;
            end
          end
          steq_pkg::OP_CANCEL: begin
            hit = cur < count_r && rdata.owned && new_r.owned &&
                  rdata.owner == new_r.owner && rdata.kind == new_r.kind;
            if (hit) begin
              res_rtc_nxt = !new_r.kind && rdata.etype == rtc_r;
              pos_nxt     = cur;
              idx_nxt     = idx_r;
              raddr       = idx_r[IB-1:0];
              state_nxt   = steq_pkg::S_SHIFT_DN;
            end else if (cur + CB'(1) < count_r && new_r.owned) begin
              state_nxt = steq_pkg::S_SCAN;
            end else begin
              res_status_nxt = steq_pkg::ST_NOTFOUND;
            end
          end
          steq_pkg::OP_QUERY: begin
            if (count_r == '0) begin
              res_status_nxt = steq_pkg::ST_EMPTY;
            end else if (rdata.expiry > now_r) begin
              res_wait_nxt = 32'(rdata.expiry - now_r);
            end
          end
          default: begin
          end
        endcase
        if (state_nxt == steq_pkg::S_DONE) begin
          valid_nxt = 1'b1;
          state_nxt = steq_pkg::S_IDLE;
        end
      end
      steq_pkg::S_SHIFT_UP: begin
        // idx_r is the slot being filled; data of idx_r - 1 is read first.
        if (idx_r == pos_r) begin
          we        = 1'b1;
          waddr     = idx_r[IB-1:0];
          wdata     = new_r;
          count_nxt = count_r + CB'(1);
          valid_nxt = 1'b1;
          state_nxt = steq_pkg::S_IDLE;
        end else if (!rd_pend_r) begin
          raddr       = cur[IB-1:0];
          rd_pend_nxt = 1'b1;
        end else begin
          we      = 1'b1;
          waddr   = idx_r[IB-1:0];
          wdata   = rdata;
          idx_nxt = cur;
        end
      end
      steq_pkg::S_SHIFT_DN: begin
        // Move entry idx_r to idx_r - 1 until the tail.
        if (idx_r >= count_r) begin
          count_nxt = count_r - CB'(1);
          valid_nxt = 1'b1;
          state_nxt = steq_pkg::S_IDLE;
        end else if (!rd_pend_r) begin
          raddr       = idx_r[IB-1:0];
          rd_pend_nxt = 1'b1;
        end else begin
          we      = 1'b1;
          waddr   = cur[IB-1:0];
          wdata   = rdata;
          idx_nxt = idx_r + CB'(1);
        end
      end
      default: begin
        state_nxt = steq_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid              = valid_r;
  assign out_status             = res_status_r;
  assign out_evt_code           = res_type_r;
  assign out_has_owner          = res_owned_r;
  assign out_owner_id           = res_owner_r;
  assign out_slot_kind          = res_kind_r;
  assign out_wait_time          = res_wait_r;
  assign out_retransmit_cleared = res_rtc_r;

`include "sorted_timer_event_queue_defines.svh"

  `STEQ_ASSERT_NXT(a_one_result, accept, !out_valid, "result in the cycle after accept")
  `STEQ_ASSERT_IMP(a_count_max, 1'b1, count_r <= CB'(steq_pkg::QueueDepth), "count overflow")
  `STEQ_ASSERT_IMP(a_valid_idle, out_valid, !busy, "result while busy")
  `STEQ_ASSERT_IMP(a_rtc_ok, out_valid && out_retransmit_cleared,
                   out_status == steq_pkg::ST_OK, "retransmit flag with error status")

endmodule

// File: tb/sv/sorted_timer_event_queue_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted timer event queue testbench
// Drives directed and random schedule, pop, cancel, query and unused opcodes;
// checks each result against a behavioral queue model or a fixed expectation.
// ----------------------------------------------------------------------------
module sorted_timer_event_queue_tb;

  localparam int WatchdogLimit = 20000;
  localparam logic [2:0] OP_BAD = 3'd7;
  localparam logic [2:0] OP_SPARE = 3'd5;

  typedef struct {
    logic [2:0]  opcode;
    logic [31:0] now_time;
    logic [31:0] delay;
    logic [3:0]  etype;
    logic        owned;
    logic [7:0]  owner;
    logic        kind;
  } req_t;

  typedef struct {
    logic [2:0]  status;
    logic [3:0]  etype;
    logic        owned;
    logic [7:0]  owner;
    logic        kind;
    logic [31:0] wait_time;
    logic        rtx;
  } resp_t;

  typedef struct {
    req_t  req;
    bit    fixed;
    resp_t resp;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [2:0] in_opcode = '0;
  logic [31:0] in_now_time = '0;
  logic [31:0] in_delay = '0;
  logic [3:0] in_evt_code = '0;
  logic in_has_owner = 1'b0;
  logic [7:0] in_owner_id = '0;
  logic in_slot_kind = 1'b0;
  logic cfg_we = 1'b0;
  logic [3:0] cfg_wdata = '0;
  logic out_valid;
  logic [2:0] out_status;
  logic [3:0] out_evt_code;
  logic out_has_owner;
  logic [7:0] out_owner_id;
  logic out_slot_kind;
  logic [31:0] out_wait_time;
  logic out_retransmit_cleared;

  sorted_timer_event_queue dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_opcode(in_opcode), .in_now_time(in_now_time), .in_delay(in_delay),
    .in_evt_code(in_evt_code), .in_has_owner(in_has_owner),
    .in_owner_id(in_owner_id), .in_slot_kind(in_slot_kind),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .out_valid(out_valid), .out_status(out_status),
    .out_evt_code(out_evt_code), .out_has_owner(out_has_owner),
    .out_owner_id(out_owner_id), .out_slot_kind(out_slot_kind),
    .out_wait_time(out_wait_time),
    .out_retransmit_cleared(out_retransmit_cleared)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  steq_pkg::entry_t timer_q[$];
  logic [3:0] rtx_code = '0;
  resp_t pending_results[$];
  int errors = 0;
  int results_seen = 0;
  int items_sent = 0;
  int idle_cycles = 0;
  bit timed_out = 1'b0;
  int n_full = 0;
  int n_busy = 0;
  int n_rtx = 0;
  int max_depth = 0;

  function automatic int find_slot(logic [7:0] owner, logic kind);
    for (int i = 0; i < timer_q.size(); i++)
      if (timer_q[i].owned && timer_q[i].owner == owner && timer_q[i].kind == kind)
        return i;
    return -1;
  endfunction

  function automatic resp_t queue_step(req_t r);
    resp_t o;
    steq_pkg::entry_t e;
    logic [32:0] sum;
    int pos;
    o = '{default: '0};
    case (r.opcode)
      steq_pkg::OP_SCHED: begin
        sum = {1'b0, r.now_time} + {1'b0, r.delay};
        e.expiry = sum[32] ? '1 : sum[31:0];
        e.etype = r.etype;
        e.owned = r.owned;
        e.owner = r.owned ? r.owner : '0;
        e.kind = r.owned ? r.kind : 1'b0;
        if (r.owned && find_slot(r.owner, r.kind) >= 0) begin
          o.status = steq_pkg::ST_BUSY;
        end else if (timer_q.size() >= steq_pkg::QueueDepth) begin
          o.status = steq_pkg::ST_FULL;
        end else begin
          pos = 0;
          while (pos < timer_q.size() && timer_q[pos].expiry < e.expiry) pos++;
          timer_q.insert(pos, e);
        end
      end
      steq_pkg::OP_POPEXP, steq_pkg::OP_POP: begin
        if (timer_q.size() == 0) begin
          o.status = steq_pkg::ST_EMPTY;
        end else if (r.opcode == steq_pkg::OP_POPEXP && r.now_time < timer_q[0].expiry) begin
          o.status = steq_pkg::ST_NOTDUE;
        end else begin
          e = timer_q.pop_front();
          o.etype = e.etype;
          o.owned = e.owned;
          o.owner = e.owner;
          o.kind = e.kind;
        end
      end
      steq_pkg::OP_CANCEL: begin
        pos = r.owned ? find_slot(r.owner, r.kind) : -1;
        if (pos < 0) begin
          o.status = steq_pkg::ST_NOTFOUND;
        end else begin
          o.rtx = (r.kind == 1'b0) && (timer_q[pos].etype == rtx_code);
          timer_q.delete(pos);
        end
      end
      steq_pkg::OP_QUERY: begin
        if (timer_q.size() == 0) o.status = steq_pkg::ST_EMPTY;
        else if (timer_q[0].expiry > r.now_time) o.wait_time = timer_q[0].expiry - r.now_time;
      end
      default: ;
    endcase
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("MISMATCH result %0d %s: got %0h expected %0h", results_seen, what, got, want);
  endtask

  always @(posedge clk) begin
    resp_t w;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("MISMATCH unexpected result %0d", results_seen);
      end else begin
        w = pending_results.pop_front();
        if (out_status !== w.status)
          report_mismatch("status", 32'(out_status), 32'(w.status));
        if (out_evt_code !== w.etype)
          report_mismatch("evt_code", 32'(out_evt_code), 32'(w.etype));
        if (out_has_owner !== w.owned)
          report_mismatch("has_owner", 32'(out_has_owner), 32'(w.owned));
        if (out_owner_id !== w.owner)
          report_mismatch("owner_id", 32'(out_owner_id), 32'(w.owner));
        if (out_slot_kind !== w.kind)
          report_mismatch("slot_kind", 32'(out_slot_kind), 32'(w.kind));
        if (out_wait_time !== w.wait_time)
          report_mismatch("wait_time", out_wait_time, w.wait_time);
        if (out_retransmit_cleared !== w.rtx)
          report_mismatch("retransmit_cleared", 32'(out_retransmit_cleared), 32'(w.rtx));
      end
      results_seen++;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || out_valid || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= WatchdogLimit);
    timed_out = 1'b1;
    $display("DONE: errors detected");
    $finish;
  end

  task automatic send_item(req_t r, bit fixed, resp_t want);
    resp_t p;
    start <= 1'b1;
    in_opcode <= r.opcode;
    in_now_time <= r.now_time;
    in_delay <= r.delay;
    in_evt_code <= r.etype;
    in_has_owner <= r.owned;
    in_owner_id <= r.owner;
    in_slot_kind <= r.kind;
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
    p = queue_step(r);
    if (timer_q.size() > max_depth) max_depth = timer_q.size();
    if (p.status == steq_pkg::ST_FULL) n_full++;
    if (p.status == steq_pkg::ST_BUSY) n_busy++;
    if (p.rtx) n_rtx++;
    pending_results.push_back(fixed ? want : p);
    items_sent++;
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2 * steq_pkg::QueueDepth + 8) @(posedge clk);
  endtask

  task automatic write_rtx_code(logic [3:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    rtx_code = v;
  endtask

  function automatic req_t mk(logic [2:0] op, logic [31:0] now_t, logic [31:0] dly,
                              logic [3:0] et, logic own, logic [7:0] oid, logic k);
    req_t r;
    r.opcode = op; r.now_time = now_t; r.delay = dly; r.etype = et;
    r.owned = own; r.owner = oid; r.kind = k;
    return r;
  endfunction

  function automatic resp_t st_only(logic [2:0] s);
    resp_t o;
    o = '{default: '0};
    o.status = s;
    return o;
  endfunction

  function automatic req_t rand_req(int phase);
    req_t r;
    int pick;
    pick = $urandom_range(99);
    r = mk(steq_pkg::OP_SCHED, $urandom, $urandom, 4'($urandom), 1'($urandom),
           8'($urandom), 1'($urandom));
    if (pick < 70) begin
      r.owner = 8'($urandom_range(7));
      r.now_time = 32'h1000 + $urandom_range(200);
      r.delay = $urandom_range(60);
      if ($urandom_range(9) == 0) r.delay = $urandom;
      if ($urandom_range(9) == 0) r.now_time = $urandom;
      pick = $urandom_range(99);
      if (phase == 1) pick = pick / 3;
      if (pick < 40) r.opcode = steq_pkg::OP_SCHED;
      else if (pick < 55) r.opcode = steq_pkg::OP_POPEXP;
      else if (pick < 65) r.opcode = steq_pkg::OP_POP;
      else if (pick < 85) r.opcode = steq_pkg::OP_CANCEL;
      else r.opcode = steq_pkg::OP_QUERY;
    end else if (pick < 95) begin
      r.opcode = 3'($urandom_range(4));
    end else begin
      r.opcode = 3'($urandom_range(7));
    end
    return r;
  endfunction

  row_t rows[$];

  initial begin
    resp_t none;
    resp_t w;
    none = '{default: '0};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    rows.push_back('{mk(steq_pkg::OP_POP, 0, 0, 0, 0, 0, 0), 1,
                     st_only(steq_pkg::ST_EMPTY)});
    rows.push_back('{mk(steq_pkg::OP_POPEXP, '1, 0, 0, 0, 0, 0), 1,
                     st_only(steq_pkg::ST_EMPTY)});
    rows.push_back('{mk(steq_pkg::OP_QUERY, 0, 0, 0, 0, 0, 0), 1,
                     st_only(steq_pkg::ST_EMPTY)});
    rows.push_back('{mk(steq_pkg::OP_CANCEL, 0, 0, 0, 1, 8'hff, 1), 1,
                     st_only(steq_pkg::ST_NOTFOUND)});
    rows.push_back('{mk(OP_BAD, '1, '1, 4'hf, 1, 8'hff, 1), 1, none});
    rows.push_back('{mk(OP_SPARE, 0, 0, 0, 0, 0, 0), 1, none});
    rows.push_back('{mk(steq_pkg::OP_SCHED, '1, '1, 4'hf, 1, 8'hff, 1), 1, none});
    rows.push_back('{mk(steq_pkg::OP_SCHED, 0, 0, 0, 1, 8'hff, 1), 1,
                     st_only(steq_pkg::ST_BUSY)});
    rows.push_back('{mk(steq_pkg::OP_SCHED, 0, 0, 4'h0, 1, 8'h00, 0), 0, none});
    rows.push_back('{mk(steq_pkg::OP_SCHED, 32'h10, 32'h10, 4'h5, 0, 8'haa, 1), 0, none});
    rows.push_back('{mk(steq_pkg::OP_SCHED, 32'h20, 0, 4'h6, 0, 8'h55, 0), 0, none});
    rows.push_back('{mk(steq_pkg::OP_QUERY, 32'h5, 0, 0, 0, 0, 0), 0, none});
    rows.push_back('{mk(steq_pkg::OP_QUERY, '1, 0, 0, 0, 0, 0), 0, none});
    rows.push_back('{mk(steq_pkg::OP_POPEXP, 0, 0, 0, 0, 0, 0), 0, none});
    rows.push_back('{mk(steq_pkg::OP_POPEXP, 32'h1f, 0, 0, 0, 0, 0), 0, none});
    rows.push_back('{mk(steq_pkg::OP_CANCEL, 0, 0, 0, 0, 8'hff, 1), 1,
                     st_only(steq_pkg::ST_NOTFOUND)});
    rows.push_back('{mk(steq_pkg::OP_CANCEL, 0, 0, 0, 1, 8'hff, 1), 0, none});
    rows.push_back('{mk(steq_pkg::OP_POP, 0, 0, 0, 0, 0, 0), 0, none});
    rows.push_back('{mk(steq_pkg::OP_POP, 0, 0, 0, 0, 0, 0), 0, none});
    foreach (rows[i]) send_item(rows[i].req, rows[i].fixed, rows[i].resp);
    drain_results();

    write_rtx_code(4'hf);
    for (int i = 0; i < 17; i++)
      send_item(mk(steq_pkg::OP_SCHED, 32'h100, 32'(17 - i), 4'hf, 1'b1, 8'(i), 1'b0),
                0, none);
    send_item(mk(steq_pkg::OP_CANCEL, 0, 0, 0, 1, 8'd3, 0), 0, none);
    drain_results();

    for (int ph = 0; ph < 4; ph++) begin
      write_rtx_code(ph == 3 ? 4'h0 : 4'($urandom));
      for (int n = 0; n < 100; n++) begin
        if (ph < 3 && $urandom_range(5) == 0) begin
          start <= 1'b0;
          repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        send_item(rand_req(ph % 2), 0, none);
        if (ph == 1 && n == 50) begin
          start <= 1'b0;
          while (pending_results.size() != 0) @(posedge clk);
        end
      end
      drain_results();
    end

    if (!timed_out) begin
      $display("Covered %0d items, %0d results, queue depth up to %0d.",
               items_sent, results_seen, max_depth);
      $display("Full rejects %0d, slot-busy rejects %0d, retransmit clears %0d.",
               n_full, n_busy, n_rtx);
      if (errors == 0 && pending_results.size() == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
    end
  end
endmodule

// File: sorted_timer_event_queue.f
+incdir+design
design/steq_pkg.sv
design/steq_ram.sv
design/sorted_timer_event_queue.sv
tb/sv/sorted_timer_event_queue_tb.sv
